// File: hdl/lavm_pkg.sv
// Shared types and arithmetic helpers for the look-at view matrix block.
`default_nettype none
package lavm_pkg;

  localparam int UnitOne = 16384;

  typedef struct packed {
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [31:0] aim_x;
    logic signed [31:0] aim_y;
    logic signed [31:0] aim_z;
    logic signed [31:0] sky_x;
    logic signed [31:0] sky_y;
    logic signed [31:0] sky_z;
  } lavm_in_t;

  typedef struct packed {
    logic [1:0]         row_index;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic signed [31:0] offset;
    logic               last_row;
    logic               degenerate;
  } lavm_out_t;

  // Queued job: eye, forward difference at full width, and sky.
  typedef struct packed {
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [33:0] dif_x;
    logic signed [33:0] dif_y;
    logic signed [33:0] dif_z;
    logic signed [31:0] sky_x;
    logic signed [31:0] sky_y;
    logic signed [31:0] sky_z;
  } lavm_job_t;

  // Result of one pass through the normalising unit.
  typedef struct packed {
    logic               done;
    logic               ok;
    logic signed [15:0] u_x;
    logic signed [15:0] u_y;
    logic signed [15:0] u_z;
  } lavm_unit_res_t;

  // One component of a cross product of Q1.14 vectors: a1*b2 - a2*b1.
  function automatic logic signed [33:0] cross_term(input logic signed [15:0] a1,
                                                    input logic signed [15:0] b2,
                                                    input logic signed [15:0] a2,
                                                    input logic signed [15:0] b1);
    logic signed [33:0] p1;
    logic signed [33:0] p2;
    p1 = 34'(a1 * b2);
    p2 = 34'(a2 * b1);
    return p1 - p2;
  endfunction

  // Q2.28 to Q1.14, rounding half away from zero, clamped to +-1.0.
  function automatic logic signed [15:0] up_round(input logic signed [33:0] v);
    logic [33:0] mag;
    logic [19:0] m2;
    mag = v[33] ? 34'(-v) : 34'(v);
    m2  = 20'((mag + 34'd8192) >> 14);
    if (m2 > 20'(UnitOne)) begin
      m2 = 20'(UnitOne);
    end
    return v[33] ? 16'(-$signed({1'b0, m2[14:0]})) : 16'({1'b0, m2[14:0]});
  endfunction

endpackage
`default_nettype wire

// File: hdl/lavm_front.sv
// Front end: accepts input words, forms the forward difference and queues jobs.
`default_nettype none
module lavm_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire lavm_pkg::lavm_in_t  in_item,
  output logic                     head_valid,
  output lavm_pkg::lavm_job_t      head,
  input  wire logic                pop
);

  lavm_pkg::lavm_job_t q_r [2];
  logic                wr_ptr_r, wr_ptr_nxt;
  logic                rd_ptr_r, rd_ptr_nxt;
  logic [1:0]          cnt_r, cnt_nxt;
  logic                push;
  lavm_pkg::lavm_job_t job;

  assign busy       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head       = q_r[rd_ptr_r];
  assign push       = start && !busy;

  always_comb begin
    job.eye_x = in_item.eye_x;
    job.eye_y = in_item.eye_y;
    job.eye_z = in_item.eye_z;
    // The difference is taken two bits wider than the inputs so it never wraps.
    job.dif_x = 34'($signed(in_item.aim_x)) - 34'($signed(in_item.eye_x));
    job.dif_y = 34'($signed(in_item.aim_y)) - 34'($signed(in_item.eye_y));
    job.dif_z = 34'($signed(in_item.aim_z)) - 34'($signed(in_item.eye_z));
    job.sky_x = in_item.sky_x;
    job.sky_y = in_item.sky_y;
    job.sky_z = in_item.sky_z;
  end

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= job;
    end
  end

endmodule
`default_nettype wire

// File: hdl/lavm_unit.sv
// Normalising unit: scales a vector, takes its length and divides it out, to Q1.14.
`default_nettype none
module lavm_unit (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                go,
  input  wire logic signed [33:0]  c_x,
  input  wire logic signed [33:0]  c_y,
  input  wire logic signed [33:0]  c_z,
  output lavm_pkg::lavm_unit_res_t res
);

  typedef enum logic [4:0] {
    U_IDLE = 5'b00001,
    U_NORM = 5'b00010,
    U_SQ   = 5'b00100,
    U_ROOT = 5'b01000,
    U_DIV  = 5'b10000
  } ustate_t;

  ustate_t     state_r;
  logic [2:0]  neg_r;
  logic [33:0] a0_r, a1_r, a2_r, m_r;
  logic [63:0] sq_r, root_r, bit_r;
  logic [1:0]  idx_r;
  logic [45:0] dv_r, rem0_r, rem1_r, rem2_r;
  logic [14:0] q0_r, q1_r, q2_r;
  logic [3:0]  step_r;
  logic        done_r, ok_r;

  logic [33:0] ax, ay, az, mx;
  logic [30:0] sel;
  logic [61:0] prod;
  logic [63:0] trial, root_nxt;
  logic [31:0] n;

  always_comb begin
    ax = c_x[33] ? 34'(-c_x) : 34'(c_x);
    ay = c_y[33] ? 34'(-c_y) : 34'(c_y);
    az = c_z[33] ? 34'(-c_z) : 34'(c_z);
    mx = ax;
    if (ay > mx) begin
      mx = ay;
    end
    if (az > mx) begin
      mx = az;
    end
  end

  always_comb begin
    case (idx_r)
      2'd0:    sel = a0_r[30:0];
      2'd1:    sel = a1_r[30:0];
      default: sel = a2_r[30:0];
    endcase
    prod  = sel * sel;
    trial = root_r + bit_r;
    if (sq_r >= trial) begin
      root_nxt = (root_r >> 1) + bit_r;
    end else begin
      root_nxt = root_r >> 1;
    end
    n = root_nxt[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
      done_r  <= 1'b0;
      ok_r    <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        U_IDLE: begin
          if (go) begin
            if (mx == 34'd0) begin
              done_r <= 1'b1;
              ok_r   <= 1'b0;
            end else begin
              state_r <= U_NORM;
            end
          end
        end
        U_NORM: begin
          if (m_r[33:31] == 3'd0 && m_r[30]) begin
            state_r <= U_SQ;
          end
        end
        U_SQ: begin
          if (idx_r == 2'd2) begin
            state_r <= U_ROOT;
          end
        end
        U_ROOT: begin
          if (bit_r[0]) begin
            state_r <= U_DIV;
          end
        end
        U_DIV: begin
          if (step_r == 4'd14) begin
            state_r <= U_IDLE;
            done_r  <= 1'b1;
            ok_r    <= 1'b1;
          end
        end
        default: state_r <= U_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      U_IDLE: begin
        neg_r <= {c_z[33], c_y[33], c_x[33]};
        a0_r  <= ax;
        a1_r  <= ay;
        a2_r  <= az;
        m_r   <= mx;
      end
      U_NORM: begin
        // Shift all three together until the largest lies in [2^30, 2^31).
        if (m_r[33:31] != 3'd0) begin
          a0_r <= a0_r >> 1;
          a1_r <= a1_r >> 1;
          a2_r <= a2_r >> 1;
          m_r  <= m_r >> 1;
        end else if (!m_r[30]) begin
          a0_r <= a0_r << 1;
          a1_r <= a1_r << 1;
          a2_r <= a2_r << 1;
          m_r  <= m_r << 1;
        end else begin
          idx_r <= 2'd0;
          sq_r  <= 64'd0;
        end
      end
      U_SQ: begin
        sq_r  <= sq_r + 64'(prod);
        idx_r <= idx_r + 2'd1;
        if (idx_r == 2'd2) begin
          root_r <= 64'd0;
          bit_r  <= 64'd1 << 62;
        end
      end
      U_ROOT: begin
        if (sq_r >= trial) begin
          sq_r <= sq_r - trial;
        end
        root_r <= root_nxt;
        bit_r  <= bit_r >> 2;
        if (bit_r[0]) begin
          // Numerator carries half the divisor so the quotient rounds half up.
          rem0_r <= {1'b0, a0_r[30:0], 14'd0} + 46'(n >> 1);
          rem1_r <= {1'b0, a1_r[30:0], 14'd0} + 46'(n >> 1);
          rem2_r <= {1'b0, a2_r[30:0], 14'd0} + 46'(n >> 1);
          dv_r   <= {n, 14'd0};
          q0_r   <= 15'd0;
          q1_r   <= 15'd0;
          q2_r   <= 15'd0;
          step_r <= 4'd0;
        end
      end
      U_DIV: begin
        if (rem0_r >= dv_r) begin
          rem0_r <= rem0_r - dv_r;
          q0_r   <= {q0_r[13:0], 1'b1};
        end else begin
          q0_r <= {q0_r[13:0], 1'b0};
        end
        if (rem1_r >= dv_r) begin
          rem1_r <= rem1_r - dv_r;
          q1_r   <= {q1_r[13:0], 1'b1};
        end else begin
          q1_r <= {q1_r[13:0], 1'b0};
        end
        if (rem2_r >= dv_r) begin
          rem2_r <= rem2_r - dv_r;
          q2_r   <= {q2_r[13:0], 1'b1};
        end else begin
          q2_r <= {q2_r[13:0], 1'b0};
        end
        dv_r   <= dv_r >> 1;
        step_r <= step_r + 4'd1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.done = done_r;
    res.ok   = ok_r;
    res.u_x  = neg_r[0] ? 16'(-$signed({1'b0, q0_r})) : 16'({1'b0, q0_r});
    res.u_y  = neg_r[1] ? 16'(-$signed({1'b0, q1_r})) : 16'({1'b0, q1_r});
    res.u_z  = neg_r[2] ? 16'(-$signed({1'b0, q2_r})) : 16'({1'b0, q2_r});
  end

endmodule
`default_nettype wire

// File: hdl/lavm_back.sv
// Back end: sequences the frame construction and emits the three matrix rows.
`default_nettype none
module lavm_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                head_valid,
  input  wire lavm_pkg::lavm_job_t head,
  output logic                     pop,
  output logic                     out_valid,
  output lavm_pkg::lavm_out_t      out_item
);

  typedef enum logic [6:0] {
    B_IDLE  = 7'b0000001,
    B_FWD   = 7'b0000010,
    B_SKY   = 7'b0000100,
    B_CROSS = 7'b0001000,
    B_RGT   = 7'b0010000,
    B_UPV   = 7'b0100000,
    B_EMIT  = 7'b1000000
  } bstate_t;

  bstate_t                  state_r;
  logic                     go_r;
  logic signed [33:0]       c_x_r, c_y_r, c_z_r;
  lavm_pkg::lavm_unit_res_t ures;
  logic signed [31:0]       eye_x_r, eye_y_r, eye_z_r;
  logic signed [31:0]       sky_x_r, sky_y_r, sky_z_r;
  logic signed [15:0]       f_x_r, f_y_r, f_z_r;
  logic signed [15:0]       s_x_r, s_y_r, s_z_r;
  logic signed [15:0]       r_x_r, r_y_r, r_z_r;
  logic signed [15:0]       u_x_r, u_y_r, u_z_r;
  logic                     deg_r;
  logic [1:0]               k_r;

  // First emit stage: products of the row axis with the eye.
  logic                     p_valid_r;
  logic signed [47:0]       p_x_r, p_y_r, p_z_r;
  lavm_pkg::lavm_out_t      p_meta_r;

  logic                     out_valid_r;
  lavm_pkg::lavm_out_t      out_r;
  lavm_pkg::lavm_out_t      out_nxt;

  logic signed [15:0]       row_x, row_y, row_z;
  logic signed [47:0]       dot;
  logic [47:0]              mag;
  logic [47:0]              rmag;
  logic signed [48:0]       off;

  lavm_unit u_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go_r),
    .c_x   (c_x_r),
    .c_y   (c_y_r),
    .c_z   (c_z_r),
    .res   (ures)
  );

  assign pop       = (state_r == B_IDLE) && head_valid;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  always_comb begin
    case (k_r)
      2'd0: begin
        row_x = r_x_r;
        row_y = r_y_r;
        row_z = r_z_r;
      end
      2'd1: begin
        row_x = u_x_r;
        row_y = u_y_r;
        row_z = u_z_r;
      end
      default: begin
        row_x = -f_x_r;
        row_y = -f_y_r;
        row_z = -f_z_r;
      end
    endcase
    if (deg_r) begin
      row_x = 16'sd0;
      row_y = 16'sd0;
      row_z = 16'sd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      go_r    <= 1'b0;
    end else begin
      go_r <= 1'b0;
      unique case (state_r)
        B_IDLE: begin
          if (head_valid) begin
            go_r    <= 1'b1;
            state_r <= B_FWD;
          end
        end
        B_FWD: begin
          if (ures.done) begin
            if (ures.ok) begin
              go_r    <= 1'b1;
              state_r <= B_SKY;
            end else begin
              state_r <= B_EMIT;
            end
          end
        end
        B_SKY: begin
          if (ures.done) begin
            state_r <= ures.ok ? B_CROSS : B_EMIT;
          end
        end
        B_CROSS: begin
          go_r    <= 1'b1;
          state_r <= B_RGT;
        end
        B_RGT: begin
          if (ures.done) begin
            state_r <= ures.ok ? B_UPV : B_EMIT;
          end
        end
        B_UPV: begin
          state_r <= B_EMIT;
        end
        B_EMIT: begin
          if (k_r == 2'd2) begin
            state_r <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        eye_x_r <= head.eye_x;
        eye_y_r <= head.eye_y;
        eye_z_r <= head.eye_z;
        sky_x_r <= head.sky_x;
        sky_y_r <= head.sky_y;
        sky_z_r <= head.sky_z;
        c_x_r   <= head.dif_x;
        c_y_r   <= head.dif_y;
        c_z_r   <= head.dif_z;
        deg_r   <= 1'b0;
        k_r     <= 2'd0;
      end
      B_FWD: begin
        if (ures.done) begin
          f_x_r <= ures.u_x;
          f_y_r <= ures.u_y;
          f_z_r <= ures.u_z;
          deg_r <= !ures.ok;
          c_x_r <= 34'(sky_x_r);
          c_y_r <= 34'(sky_y_r);
          c_z_r <= 34'(sky_z_r);
        end
      end
      B_SKY: begin
        if (ures.done) begin
          s_x_r <= ures.u_x;
          s_y_r <= ures.u_y;
          s_z_r <= ures.u_z;
          deg_r <= !ures.ok;
        end
      end
      B_CROSS: begin
        c_x_r <= lavm_pkg::cross_term(f_y_r, s_z_r, f_z_r, s_y_r);
        c_y_r <= lavm_pkg::cross_term(f_z_r, s_x_r, f_x_r, s_z_r);
        c_z_r <= lavm_pkg::cross_term(f_x_r, s_y_r, f_y_r, s_x_r);
      end
      B_RGT: begin
        if (ures.done) begin
          r_x_r <= ures.u_x;
          r_y_r <= ures.u_y;
          r_z_r <= ures.u_z;
          deg_r <= !ures.ok;
        end
      end
      B_UPV: begin
        // True up is right cross forward, not renormalised.
        u_x_r <= lavm_pkg::up_round(lavm_pkg::cross_term(r_y_r, f_z_r, r_z_r, f_y_r));
        u_y_r <= lavm_pkg::up_round(lavm_pkg::cross_term(r_z_r, f_x_r, r_x_r, f_z_r));
        u_z_r <= lavm_pkg::up_round(lavm_pkg::cross_term(r_x_r, f_y_r, r_y_r, f_x_r));
      end
      B_EMIT: begin
        k_r <= k_r + 2'd1;
      end
      default: begin
      end
    endcase
  end

  // Emit pipeline: multiply, then sum, round, negate and saturate.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      p_valid_r   <= (state_r == B_EMIT);
      out_valid_r <= p_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    p_x_r               <= 48'(row_x * eye_x_r);
    p_y_r               <= 48'(row_y * eye_y_r);
    p_z_r               <= 48'(row_z * eye_z_r);
    p_meta_r.row_index  <= k_r;
    p_meta_r.axis_x     <= row_x;
    p_meta_r.axis_y     <= row_y;
    p_meta_r.axis_z     <= row_z;
    p_meta_r.offset     <= 32'sd0;
    p_meta_r.last_row   <= (k_r == 2'd2);
    p_meta_r.degenerate <= deg_r;
  end

  always_comb begin
    dot  = p_x_r + p_y_r + p_z_r;
    mag  = dot[47] ? 48'(-dot) : 48'(dot);
    rmag = (mag + 48'd8192) >> 14;
    off  = dot[47] ? 49'(rmag) : -49'(rmag);
    out_nxt = p_meta_r;
    if (off > 49'sd2147483647) begin
      out_nxt.offset = 32'sh7fffffff;
    end else if (off < -49'sd2147483648) begin
      out_nxt.offset = 32'sh80000000;
    end else begin
      out_nxt.offset = off[31:0];
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

endmodule
`default_nettype wire

// File: hdl/look_at_view_matrix.sv
// Top level of the look-at view matrix block.
// A word is taken when start is high and busy is low; a two-word queue lets a
// new camera be taken while the previous one is still in work. Each camera
// gives three result words (right, up, negated forward) on consecutive cycles,
// each shown for one cycle with out_valid high; the receiver cannot stall, so
// results must be taken as they appear. How long one camera holds the back end
// depends on its scaling shifts, set by the shared normalising unit, which runs
// three passes per camera: each pass has a start, the squaring of the three
// components, 32 square-root steps, 15 divide steps and a one-bit-per-cycle
// scaling shift of up to 30 bits; the emit state follows, and each row then
// passes through the product register and the output register. A degenerate
// camera finishes early, for instance when eye and aim coincide. There is no
// clearing pass after reset.
`default_nettype none
module look_at_view_matrix (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire lavm_pkg::lavm_in_t in_item,
  output logic                    out_valid,
  output lavm_pkg::lavm_out_t     out_item
);

  logic                head_valid;
  lavm_pkg::lavm_job_t head;
  logic                pop;

  lavm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  lavm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_item   (out_item)
  );

endmodule
`default_nettype wire

// File: verif/look_at_view_matrix_tb.sv
// Self-checking testbench for the look-at view matrix block.
`default_nettype none
module look_at_view_matrix_tb;
  timeunit 1ns;
  timeprecision 1ps;

  class row_scoreboard;
    lavm_pkg::lavm_out_t pending_rows[$];
    int unsigned mismatches;

    // Normalise a vector to Q1.14; returns 0 for a zero vector.
    function bit make_unit(input longint c[3], output int u[3]);
      longint unsigned a[3];
      longint unsigned m, sum, n, bitv, res, sq, q;
      m = 0;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        a[i] = c[i] < 0 ? longint'(-c[i]) : c[i];
        if (a[i] > m) m = a[i];
      end
      if (m == 0) return 0;
      while (m >= 64'h8000_0000) begin
        m >>= 1;
        for (int i = 0; i < 3; i++) a[i] >>= 1;
      end
      while (m < 64'h4000_0000) begin
        m <<= 1;
        for (int i = 0; i < 3; i++) a[i] <<= 1;
      end
      for (int i = 0; i < 3; i++) sum += a[i] * a[i];
      sq = sum;
      res = 0;
      bitv = 64'h1 << 62;
      while (bitv > sq) bitv >>= 2;
      while (bitv != 0) begin
        if (sq >= res + bitv) begin
          sq -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      n = res;
      for (int i = 0; i < 3; i++) begin
        q = (a[i] * 16384 + n / 2) / n;
        u[i] = c[i] < 0 ? -int'(q) : int'(q);
      end
      return 1;
    endfunction

    function longint round_shift14(input longint v);
      longint unsigned mag;
      mag = v < 0 ? -v : v;
      mag = (mag + 8192) >> 14;
      return v < 0 ? -longint'(mag) : longint'(mag);
    endfunction

    function void cross3(input int a[3], input int b[3], output longint o[3]);
      o[0] = longint'(a[1]) * b[2] - longint'(a[2]) * b[1];
      o[1] = longint'(a[2]) * b[0] - longint'(a[0]) * b[2];
      o[2] = longint'(a[0]) * b[1] - longint'(a[1]) * b[0];
    endfunction

    function void note_camera(input lavm_pkg::lavm_in_t cam);
      longint eye[3], dif[3], sky[3], cr[3], dot, off, v;
      int fw[3], sk[3], rt[3], up[3], rows[3][3];
      bit ok;
      lavm_pkg::lavm_out_t w;
      eye = '{cam.eye_x, cam.eye_y, cam.eye_z};
      dif = '{longint'(cam.aim_x) - cam.eye_x, longint'(cam.aim_y) - cam.eye_y,
              longint'(cam.aim_z) - cam.eye_z};
      sky = '{cam.sky_x, cam.sky_y, cam.sky_z};
      ok = make_unit(dif, fw);
      if (ok) ok = make_unit(sky, sk);
      if (ok) begin
        cross3(fw, sk, cr);
        ok = make_unit(cr, rt);
      end
      for (int k = 0; k < 3; k++)
        for (int i = 0; i < 3; i++) rows[k][i] = 0;
      if (ok) begin
        cross3(rt, fw, cr);
        for (int i = 0; i < 3; i++) begin
          v = round_shift14(cr[i]);
          if (v > 16384) v = 16384;
          if (v < -16384) v = -16384;
          up[i] = int'(v);
          rows[0][i] = rt[i];
          rows[1][i] = up[i];
          rows[2][i] = -fw[i];
        end
      end
      for (int k = 0; k < 3; k++) begin
        dot = 0;
        for (int i = 0; i < 3; i++) dot += longint'(rows[k][i]) * eye[i];
        off = -round_shift14(dot);
        if (off > 64'sd2147483647) off = 64'sd2147483647;
        if (off < -64'sd2147483648) off = -64'sd2147483648;
        w.row_index = 2'(k);
        w.axis_x = 16'(rows[k][0]);
        w.axis_y = 16'(rows[k][1]);
        w.axis_z = 16'(rows[k][2]);
        w.offset = 32'(off);
        w.last_row = (k == 2);
        w.degenerate = !ok;
        pending_rows.push_back(w);
      end
    endfunction

    function void check_row(input lavm_pkg::lavm_out_t got);
      lavm_pkg::lavm_out_t want;
      if (pending_rows.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result word %h", got);
        return;
      end
      want = pending_rows.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected row %0d axis %0d %0d %0d off %0d last %b deg %b;",
                   want.row_index, want.axis_x, want.axis_y, want.axis_z, want.offset,
                   want.last_row, want.degenerate,
                   " got row %0d axis %0d %0d %0d off %0d last %b deg %b",
                   got.row_index, got.axis_x, got.axis_y, got.axis_z, got.offset,
                   got.last_row, got.degenerate);
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  lavm_pkg::lavm_in_t  in_item = '0;
  logic                out_valid;
  lavm_pkg::lavm_out_t out_item;
  row_scoreboard       board = new();
  bit                  calm = 1'b0;

  look_at_view_matrix uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) board.check_row(out_item);
  end

  // Hold start until the word is taken at a rising edge with busy low.
  task automatic send_camera(input lavm_pkg::lavm_in_t cam);
    bit taken;
    if (!calm && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    start <= 1'b1;
    in_item <= cam;
    taken = 0;
    while (!taken) begin
      @(posedge clk);
      taken = !busy;
    end
    board.note_camera(cam);
    @(negedge clk);
  endtask

  function automatic logic signed [31:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return 32'($signed($urandom_range(0, 40)) - 20);
      3: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      default: return 32'($urandom);
    endcase
  endfunction

  function automatic lavm_pkg::lavm_in_t random_camera();
    lavm_pkg::lavm_in_t cam;
    cam.eye_x = pick_coord(); cam.eye_y = pick_coord(); cam.eye_z = pick_coord();
    cam.aim_x = pick_coord(); cam.aim_y = pick_coord(); cam.aim_z = pick_coord();
    cam.sky_x = pick_coord(); cam.sky_y = pick_coord(); cam.sky_z = pick_coord();
    case ($urandom_range(0, 15))
      0: begin cam.aim_x = cam.eye_x; cam.aim_y = cam.eye_y; cam.aim_z = cam.eye_z; end
      1: begin cam.sky_x = 0; cam.sky_y = 0; cam.sky_z = 0; end
      // Sky along the view direction makes the frame collapse.
      2: begin
        cam.aim_x = cam.eye_x; cam.aim_z = cam.eye_z;
        cam.aim_y = cam.eye_y + 32'sh10000;
        cam.sky_x = 0; cam.sky_z = 0; cam.sky_y = -32'sh20000;
      end
      default: ;
    endcase
    return cam;
  endfunction

  initial begin
    lavm_pkg::lavm_in_t cam;
    int wait_cycles;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send_camera('{0, 0, 32'sh50000, 0, 0, 0, 0, 32'sh10000, 0});
    send_camera('{0, 0, 0, 0, 0, 0, 0, 32'sh10000, 0});
    send_camera('{0, 0, 0, 32'sh10000, 0, 0, 0, 0, 0});
    send_camera('{0, 0, 0, 0, 32'sh10000, 0, 0, 32'sh30000, 0});
    send_camera('{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000,
                  32'sh80000000, 1, 0, 0});
    send_camera('{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
                  32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000});
    send_camera('{32'sh80000000, 32'sh7fffffff, 32'sh80000000, 0, 0, 0, 0, 1, 0});
    send_camera('{32'shffffffff, 32'shffffffff, 32'shffffffff, 1, 1, 1, 32'shffffffff, 1, 0});
    send_camera('{32'sh12345678, -32'sh1234567, 32'sh7ff, 32'sh12345679, -32'sh1234567, 32'sh7ff,
                  0, 0, 32'sh7fffffff});
    send_camera('{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                  32'sh80000000, 32'sh55555555, 32'shaaaaaaaa, 32'sh0f0f0f0f});
    for (int n = 0; n < 410; n++) begin
      if (n >= 360) calm = 1'b1;
      cam = random_camera();
      send_camera(cam);
    end
    start <= 1'b0;
    wait_cycles = 0;
    while (board.pending_rows.size() != 0 && wait_cycles < 20000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (400) @(negedge clk);
    if (board.mismatches == 0 && board.pending_rows.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end
endmodule
`default_nettype wire

// File: sim.f
hdl/lavm_pkg.sv
hdl/lavm_front.sv
hdl/lavm_unit.sv
hdl/lavm_back.sv
hdl/look_at_view_matrix.sv
verif/look_at_view_matrix_tb.sv
